// ----- rtl/core/subs_pkg.sv -----
package subs_pkg;

    localparam int TEXT_DEPTH_DEF    = 1024;
    localparam int PATTERN_DEPTH_DEF = 32;

    localparam int POS_W  = 10;
    localparam int BYTE_W = 8;
    localparam int TLEN_W = 11;
    localparam int PLEN_W = 6;

    typedef enum logic [1:0] {
        REQ_WR_TEXT    = 2'd0,
        REQ_WR_PATTERN = 2'd1,
        REQ_FIND_FWD   = 2'd2,
        REQ_FIND_BWD   = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic [POS_W-1:0]    position;
        logic [BYTE_W-1:0]   byte_value;
        logic [TLEN_W-1:0]   text_length;
        logic [PLEN_W-1:0]   pattern_length;
        logic                ignore_case;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    match_position;
    } rsp_t;

endpackage

// ----- rtl/core/subs_ram.sv -----
module subs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/subs_cmp.sv -----
module subs_cmp (
    input  logic [subs_pkg::BYTE_W-1:0] text_byte,
    input  logic [subs_pkg::BYTE_W-1:0] pattern_byte,
    input  logic                        fold,
    output logic                        equal
);

    import subs_pkg::*;

    localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

    logic [BYTE_W-1:0] text_f;
    logic [BYTE_W-1:0] pattern_f;

    // fold ASCII capitals to lower case when asked
    always_comb
    begin
        text_f    = text_byte;
        pattern_f = pattern_byte;
        if (fold && text_byte >= UPPER_A && text_byte <= UPPER_Z)
        begin
            text_f = text_byte + CASE_OFS;
        end
        if (fold && pattern_byte >= UPPER_A && pattern_byte <= UPPER_Z)
        begin
            pattern_f = pattern_byte + CASE_OFS;
        end
        equal = (text_f == pattern_f);
    end

endmodule

// ----- rtl/core/subs_seq.sv -----
module subs_seq #(
    parameter int TEXT_DEPTH    = subs_pkg::TEXT_DEPTH_DEF,
    parameter int PATTERN_DEPTH = subs_pkg::PATTERN_DEPTH_DEF,
    parameter int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1,
    parameter int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  subs_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output subs_pkg::rsp_t              rsp,
    output logic                        text_we,
    output logic [TAW-1:0]              text_waddr,
    output logic [subs_pkg::BYTE_W-1:0] text_wdata,
    output logic [TAW-1:0]              text_raddr,
    input  logic [subs_pkg::BYTE_W-1:0] text_rdata,
    output logic                        pat_we,
    output logic [PAW-1:0]              pat_waddr,
    output logic [subs_pkg::BYTE_W-1:0] pat_wdata,
    output logic [PAW-1:0]              pat_raddr,
    input  logic [subs_pkg::BYTE_W-1:0] pat_rdata
);

    import subs_pkg::*;

    localparam int TD_W  = $clog2(TEXT_DEPTH + 1);
    localparam int LEN_W = ((TD_W > TLEN_W) ? TD_W : TLEN_W) + 1;
    localparam int PL_W  = $clog2(PATTERN_DEPTH + 1);
    localparam logic [LEN_W-1:0] TEXT_MAX = LEN_W'(TEXT_DEPTH);
    localparam logic [PL_W-1:0]  PAT_MAX  = PL_W'(PATTERN_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic              bwd_reg;
    logic              fold_reg;
    logic [LEN_W-1:0]  start_reg;
    logic [LEN_W-1:0]  tlen_reg;
    logic [PL_W-1:0]   plen_reg;
    logic [PAW-1:0]    k_reg;
    logic              found_reg;
    logic [POS_W-1:0]  at_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic              accept;
    logic              out_free;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  tlen_ext;
    logic [PL_W-1:0]   plen_ext;
    logic [LEN_W-1:0]  plen_w;
    logic              len_ok;
    logic [LEN_W-1:0]  last_pos;
    logic              fwd_ok;
    logic              bwd_ok;
    logic [LEN_W-1:0]  bwd_start;
    logic [LEN_W-1:0]  next_fwd;
    logic              next_fwd_ok;
    logic              last_byte;
    logic              equal;

    subs_cmp u_cmp (
        .text_byte    (text_rdata),
        .pattern_byte (pat_rdata),
        .fold         (fold_reg),
        .equal        (equal)
    );

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_ready = (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // store writes go straight in on acceptance; out-of-range indexes drop
    assign text_we    = accept && (req.req_type == REQ_WR_TEXT)
                        && (LEN_W'(req.position) < TEXT_MAX);
    assign text_waddr = TAW'(req.position);
    assign text_wdata = req.byte_value;
    assign pat_we     = accept && (req.req_type == REQ_WR_PATTERN)
                        && ((PL_W + POS_W)'(req.position) < (PL_W + POS_W)'(PATTERN_DEPTH));
    assign pat_waddr  = PAW'(req.position);
    assign pat_wdata  = req.byte_value;

    assign text_raddr = TAW'(start_reg + LEN_W'(k_reg));
    assign pat_raddr  = k_reg;

    always_comb
    begin
        pos_ext  = LEN_W'(req.position);
        tlen_ext = LEN_W'(req.text_length);
        if (tlen_ext > TEXT_MAX)
        begin
            tlen_ext = TEXT_MAX;
        end
        plen_ext = PL_W'(req.pattern_length);
        if ((PL_W + PLEN_W)'(req.pattern_length) > (PL_W + PLEN_W)'(PATTERN_DEPTH))
        begin
            plen_ext = PAT_MAX;
        end
    end

    // candidate window checks on the held request
    always_comb
    begin
        plen_w    = LEN_W'(plen_reg);
        len_ok    = (plen_reg != '0) && (tlen_reg != '0) && (plen_w <= tlen_reg);
        fwd_ok    = len_ok && (start_reg + plen_w <= tlen_reg);
        last_pos  = (start_reg > tlen_reg - 1'b1) ? (tlen_reg - 1'b1) : start_reg;
        bwd_ok    = len_ok && (last_pos + 1'b1 >= plen_w);
        bwd_start = last_pos + 1'b1 - plen_w;
        next_fwd    = start_reg + 1'b1;
        next_fwd_ok = (next_fwd + plen_w <= tlen_reg);
        last_byte   = (PL_W'(k_reg) + 1'b1 == plen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            bwd_reg       <= 1'b0;
            fold_reg      <= 1'b0;
            start_reg     <= '0;
            tlen_reg      <= '0;
            plen_reg      <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            at_reg        <= '0;
        end
        else
        begin
            // a fresh result wins over the hand-off of the old one
            if ((state_reg == ST_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        bwd_reg   <= (req.req_type == REQ_FIND_BWD);
                        fold_reg  <= req.ignore_case;
                        start_reg <= pos_ext;
                        tlen_reg  <= tlen_ext;
                        plen_reg  <= plen_ext;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        at_reg    <= '0;
                        if (req.req_type inside {REQ_FIND_FWD, REQ_FIND_BWD})
                        begin
                            state_reg <= ST_SETUP;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SETUP:
                begin
                    if (bwd_reg)
                    begin
                        start_reg <= bwd_start;
                        state_reg <= bwd_ok ? ST_RD : ST_DONE;
                    end
                    else
                    begin
                        state_reg <= fwd_ok ? ST_RD : ST_DONE;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (equal && last_byte)
                    begin
                        found_reg <= 1'b1;
                        at_reg    <= POS_W'(start_reg);
                        state_reg <= ST_DONE;
                    end
                    else if (equal)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (bwd_reg)
                        begin
                            start_reg <= start_reg - 1'b1;
                            state_reg <= (start_reg == '0) ? ST_DONE : ST_RD;
                        end
                        else
                        begin
                            start_reg <= next_fwd;
                            state_reg <= next_fwd_ok ? ST_RD : ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg.found          <= found_reg;
                        rsp_reg.match_position <= at_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/substring_find_fwd_bwd_top.sv -----
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   subs_pkg::req_t (write or search request)
// rsp       out        rsp_valid/rsp_ready   subs_pkg::rsp_t (found, match_position)
//
// A write request passes through the done state before its result register
// is loaded, so the block takes no new request until that result is loaded.
// A search passes through a setup state, then a read state and a compare
// state for each byte compared (store read, then compare); each candidate
// start reads and compares its bytes in turn up to the first mismatch,
// with the speed set by the single RAM read port of each store and the
// one shared byte comparator.
// Reset (rst_n, asynchronous) clears the sequencer and the result
// register; store contents are undefined until written.
// A stalled result holds in its register while the next request is taken.
module substring_find_fwd_bwd_top #(
    parameter int TEXT_DEPTH    = subs_pkg::TEXT_DEPTH_DEF,
    parameter int PATTERN_DEPTH = subs_pkg::PATTERN_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  subs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output subs_pkg::rsp_t rsp
);

    import subs_pkg::*;

    // address widths of the two stores
    localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

    logic              text_we;
    logic [TAW-1:0]    text_waddr;
    logic [BYTE_W-1:0] text_wdata;
    logic [TAW-1:0]    text_raddr;
    logic [BYTE_W-1:0] text_rdata;
    logic              pat_we;
    logic [PAW-1:0]    pat_waddr;
    logic [BYTE_W-1:0] pat_wdata;
    logic [PAW-1:0]    pat_raddr;
    logic [BYTE_W-1:0] pat_rdata;

    // text store: one write port for loading, one registered read port for the scan
    subs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TEXT_DEPTH),
        .AW    (TAW)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (text_we),
        .wr_addr (text_waddr),
        .wr_data (text_wdata),
        .rd_addr (text_raddr),
        .rd_data (text_rdata)
    );

    // pattern store: read in step with the text store
    subs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PATTERN_DEPTH),
        .AW    (PAW)
    ) u_pat_ram (
        .clk     (clk),
        .wr_en   (pat_we),
        .wr_addr (pat_waddr),
        .wr_data (pat_wdata),
        .rd_addr (pat_raddr),
        .rd_data (pat_rdata)
    );

    // sequencer: walk candidate starts forward or backward, one byte compare at a time
    subs_seq #(
        .TEXT_DEPTH    (TEXT_DEPTH),
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TAW           (TAW),
        .PAW           (PAW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .text_we    (text_we),
        .text_waddr (text_waddr),
        .text_wdata (text_wdata),
        .text_raddr (text_raddr),
        .text_rdata (text_rdata),
        .pat_we     (pat_we),
        .pat_waddr  (pat_waddr),
        .pat_wdata  (pat_wdata),
        .pat_raddr  (pat_raddr),
        .pat_rdata  (pat_rdata)
    );

endmodule

// ----- rtl/core/subs_chk.sv -----
module subs_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input subs_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input subs_pkg::rsp_t rsp
);

    import subs_pkg::*;

    // hold a stalled result unchanged
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    // a miss reports position zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.match_position == '0)
        else $error("miss with non-zero position");

    // an accepted request always leaves the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted without going busy");

    // a new result only follows a busy cycle
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a request in flight");

endmodule

bind substring_find_fwd_bwd_top subs_chk u_subs_chk (.*);
